// ===== hw/rtl/stt_pkg.sv =====
// Shared widths, character codes, command codes and controller states for the text terminal.
package stt_pkg;

  localparam int NUM_ROWS_DEF = 24;
  localparam int NUM_COLS_DEF = 40;

  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int ROW_FW     = 5;
  localparam int COL_FW     = 6;
  localparam int CHAR_W     = 7;

  localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [BYTE_W-1:0] CH_RETURN     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL        = 8'h7f;

  localparam logic [1:0] BLINK_LAST = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_BLINK = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BLANK,
    ST_MARK,
    ST_RDATA
  } state_t;

endpackage

// ===== hw/rtl/scrolling_text_terminal.sv =====
// Top level of the character-cell text terminal with a scrolling screen memory.
//
// A command beat is taken when start is high and busy is low. Command 0 writes a
// byte to the terminal, command 1 advances the cursor blink phase, command 2 reads
// one screen cell for the video scanout, and command 3 does nothing. Every command
// returns exactly one result beat, marked by out_valid for a single cycle, carrying
// the cell character (reads only), the cursor position after the command and a flag
// that tells whether a write scrolled the screen. The receiver cannot stall.
// Blink and unused commands never raise busy and answer in the cycle after
// acceptance. A read answers from ST_RDATA, which takes the registered memory
// port's data. A write answers from ST_MARK, passing first through ST_BLANK when
// it scrolls: rows are addressed through a top-row pointer, so a scroll only
// blanks the new bottom row, one cell per cycle through the single write port.
// After reset the block holds busy high while it fills all NUM_ROWS * NUM_COLS
// screen cells with spaces; the cursor and blink phase start at zero.
module scrolling_text_terminal
  import stt_pkg::*;
#(
  parameter int NUM_ROWS = NUM_ROWS_DEF,
  parameter int NUM_COLS = NUM_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [ROW_FW-1:0] in_read_row,
  input  logic [COL_FW-1:0] in_read_col,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_cell_char,
  output logic [ROW_FW-1:0] out_cursor_row,
  output logic [COL_FW-1:0] out_cursor_col,
  output logic              out_scrolled
);

  localparam int RW    = $clog2(NUM_ROWS);
  localparam int CW    = $clog2(NUM_COLS);
  localparam int DEPTH = NUM_ROWS * NUM_COLS;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] row);
    logic [RW:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= (RW+1)'(NUM_ROWS)) begin
      sum = sum - (RW+1)'(NUM_ROWS);
    end
    return sum[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    return AW'(32'(row) * NUM_COLS + 32'(col));
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [RW-1:0]     top_r, top_nxt;
  logic [RW-1:0]     blank_row_r, blank_row_nxt;
  logic [CW-1:0]     blank_col_r, blank_col_nxt;
  logic              scroll_r, scroll_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_cell_char_r, out_cell_char_nxt;
  logic              out_scrolled_r, out_scrolled_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  logic              accept;
  logic              wr_put;
  logic [CHAR_W-1:0] wr_char;
  logic [RW-1:0]     wr_row;
  logic [CW-1:0]     wr_col;
  logic              wr_scroll;
  logic              row_inc;
  logic [1:0]        blink_phase;
  logic              rd_ok;
  logic [AW-1:0]     cur_addr;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign cur_addr = cell_addr(phys_row(top_r, cur_row_r), cur_col_r);
  assign rd_ok = (32'(in_read_row) < NUM_ROWS) && (32'(in_read_col) < NUM_COLS);
  assign blink_phase = (phase_r == BLINK_LAST) ? 2'd0 : phase_r + 2'd1;

  always_comb begin
    wr_put    = 1'b0;
    wr_char   = CH_SPACE[CHAR_W-1:0];
    wr_row    = cur_row_r;
    wr_col    = cur_col_r;
    row_inc   = 1'b0;
    wr_scroll = 1'b0;
    priority if (in_data_byte == CH_UNDERSCORE) begin
      wr_put = 1'b1;
      if (cur_col_r == '0) begin
        if (cur_row_r != '0) begin
          wr_row = cur_row_r - RW'(1);
          wr_col = CW'(NUM_COLS - 1);
        end
      end else begin
        wr_col = cur_col_r - CW'(1);
      end
    end else if (in_data_byte == CH_RETURN) begin
      wr_put  = 1'b1;
      wr_col  = '0;
      row_inc = 1'b1;
    end else if (in_data_byte >= CH_SPACE && in_data_byte < CH_DEL) begin
      wr_put  = 1'b1;
      wr_char = in_data_byte[CHAR_W-1:0];
      if (cur_col_r == CW'(NUM_COLS - 1)) begin
        wr_col  = '0;
        row_inc = 1'b1;
      end else begin
        wr_col = cur_col_r + CW'(1);
      end
    end else begin
      wr_put = 1'b0;
    end
    if (row_inc) begin
      if (cur_row_r == RW'(NUM_ROWS - 1)) begin
        wr_scroll = 1'b1;
      end else begin
        wr_row = cur_row_r + RW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_WRITE: state_nxt = wr_scroll ? ST_BLANK : ST_MARK;
            CMD_READ:  state_nxt = ST_RDATA;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BLANK: begin
        if (blank_col_r == CW'(NUM_COLS - 1)) begin
          state_nxt = ST_MARK;
        end
      end
      ST_MARK:  state_nxt = ST_IDLE;
      ST_RDATA: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we            = 1'b0;
    mem_waddr         = cur_addr;
    mem_wdata         = CH_SPACE[CHAR_W-1:0];
    mem_re            = 1'b0;
    mem_raddr         = cell_addr(phys_row(top_r, RW'(in_read_row)), CW'(in_read_col));
    clr_cnt_nxt       = clr_cnt_r;
    cur_row_nxt       = cur_row_r;
    cur_col_nxt       = cur_col_r;
    phase_nxt         = phase_r;
    top_nxt           = top_r;
    blank_row_nxt     = blank_row_r;
    blank_col_nxt     = blank_col_r;
    scroll_nxt        = scroll_r;
    rd_ok_nxt         = rd_ok_r;
    out_valid_nxt     = 1'b0;
    out_cell_char_nxt = out_cell_char_r;
    out_scrolled_nxt  = out_scrolled_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_WRITE: begin
              mem_we      = wr_put;
              mem_wdata   = wr_char;
              cur_row_nxt = wr_row;
              cur_col_nxt = wr_col;
              scroll_nxt  = wr_scroll;
              if (wr_scroll) begin
                top_nxt       = phys_row(top_r, RW'(1));
                blank_row_nxt = top_r;
                blank_col_nxt = '0;
              end
            end
            CMD_BLINK: begin
              phase_nxt         = blink_phase;
              mem_we            = 1'b1;
              mem_wdata         = (blink_phase != BLINK_LAST) ?
                                  CH_UNDERSCORE[CHAR_W-1:0] : CH_SPACE[CHAR_W-1:0];
              out_valid_nxt     = 1'b1;
              out_cell_char_nxt = '0;
              out_scrolled_nxt  = 1'b0;
            end
            CMD_READ: begin
              mem_re    = rd_ok;
              rd_ok_nxt = rd_ok;
            end
            default: begin
              out_valid_nxt     = 1'b1;
              out_cell_char_nxt = '0;
              out_scrolled_nxt  = 1'b0;
            end
          endcase
        end
      end
      ST_BLANK: begin
        mem_we        = 1'b1;
        mem_waddr     = cell_addr(blank_row_r, blank_col_r);
        blank_col_nxt = blank_col_r + CW'(1);
      end
      ST_MARK: begin
        mem_we            = 1'b1;
        mem_wdata         = CH_UNDERSCORE[CHAR_W-1:0];
        out_valid_nxt     = 1'b1;
        out_cell_char_nxt = '0;
        out_scrolled_nxt  = scroll_r;
      end
      ST_RDATA: begin
        out_valid_nxt     = 1'b1;
        out_cell_char_nxt = rd_ok_r ? mem_rdata : '0;
        out_scrolled_nxt  = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      phase_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      phase_r     <= phase_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blank_row_r     <= blank_row_nxt;
    blank_col_r     <= blank_col_nxt;
    scroll_r        <= scroll_nxt;
    rd_ok_r         <= rd_ok_nxt;
    out_cell_char_r <= out_cell_char_nxt;
    out_scrolled_r  <= out_scrolled_nxt;
  end

  stt_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_screen_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_cell_char_r;
  assign out_cursor_row = ROW_FW'(cur_row_r);
  assign out_cursor_col = COL_FW'(cur_col_r);
  assign out_scrolled   = out_scrolled_r;

endmodule

// ===== hw/rtl/stt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
